>>> src/bkc_pkg.sv
`default_nettype none

package bkc_pkg;

	localparam int unsigned DataW   = 8;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [DataW-1:0]   byte_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// register indexes of the configuration port
	localparam cfg_idx_t CFG_INITIAL_KEY     = 2'd0;
	localparam cfg_idx_t CFG_INITIAL_COUNTER = 2'd1;

	// reset values of the keystream state
	localparam byte_t KEY_RESET     = 8'b1011_0010;
	localparam byte_t COUNTER_RESET = 8'b0010_1000;

	// x / 9 for x < 256 equals (x * 57) >> 9
	localparam int unsigned Mod9Mult  = 57;
	localparam int unsigned Mod9Shift = 9;
	localparam int unsigned Mod9ProdW = 14;

	// output mask codes
	localparam byte_t MASK_EVEN = 8'h55;
	localparam byte_t MASK_ODD  = 8'hAA;
	localparam byte_t MASK_ALL  = 8'hFF;

	// rewrite bits top down, each xored with the bit one or two places up (wrapping modulo 8),
	// then count up by one
	function automatic byte_t advance_counter(input byte_t key, input byte_t cnt);
		byte_t      t;
		logic [2:0] nb;
		t = cnt;
		for (int i = DataW - 1; i >= 0; i--) begin
			nb   = key[i] ? 3'(i + 1) : 3'(i + 2);
			t[i] = t[i] ^ t[nb];
		end
		return t + byte_t'(1);
	endfunction

	// pick the mask from the counter's residue mod 9
	function automatic byte_t select_mask(input byte_t cnt);
		logic [Mod9ProdW-1:0] prod;
		byte_t                quot;
		logic [3:0]           rem;
		byte_t                mask;
		prod = Mod9ProdW'(cnt) * Mod9ProdW'(Mod9Mult);
		quot = byte_t'(prod >> Mod9Shift);
		rem  = 4'(cnt - byte_t'(quot * byte_t'(9)));
		if (rem < 4'd3) begin
			mask = MASK_EVEN;
		end else if (rem < 4'd6) begin
			mask = MASK_ODD;
		end else begin
			mask = MASK_ALL;
		end
		return mask;
	endfunction

endpackage

`default_nettype wire

>>> src/byte_keystream_cipher.sv
`default_nettype none

// Byte stream cipher: every input beat carries one byte (tdata) and a start
// flag (tuser); every byte yields one output byte, data XOR a mask of the
// advanced keystream counter, so encryption and decryption are the same
// operation. A start flag reloads key and counter from the initial_key and
// initial_counter registers before that byte; writes to those registers act
// only at the next start. One byte per clock is sustained while the output
// accepts: the input stage register feeds the combinational counter logic,
// whose result the output register captures. Config writes are always
// accepted and must be made while no bytes are in flight.
module byte_keystream_cipher (
	input  wire                    clk,
	input  wire                    arst_n,
	// input stream
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire  [7:0]             s_axis_tdata,  // [7:0] data_in
	input  wire                    s_axis_tuser,  // [0] start_message
	// output stream
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [7:0]             m_axis_tdata,  // [7:0] data_out
	// config writes
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  bkc_pkg::cfg_idx_t cfg_index,
	input  wire  bkc_pkg::byte_t   cfg_data
);
	import bkc_pkg::*;

	byte_t initial_key_q;
	byte_t initial_counter_q;
	byte_t key_q;
	byte_t counter_q;

	logic  valid_s1;
	byte_t data_s1;
	logic  start_s1;

	logic  advance;
	byte_t key_cur;
	byte_t cnt_cur;
	byte_t cnt_next;
	byte_t result;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_key_q     <= KEY_RESET;
			initial_counter_q <= COUNTER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INITIAL_KEY:     initial_key_q     <= cfg_data;
				CFG_INITIAL_COUNTER: initial_counter_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or drains
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// keystream step
	always_comb begin
		key_cur  = start_s1 ? initial_key_q : key_q;
		cnt_cur  = start_s1 ? initial_counter_q : counter_q;
		cnt_next = advance_counter(key_cur, cnt_cur);
		result   = data_s1 ^ (cnt_next & select_mask(cnt_next));
	end

	// keystream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= KEY_RESET;
			counter_q <= COUNTER_RESET;
		end else if (advance) begin
			key_q     <= key_cur + byte_t'(1);
			counter_q <= cnt_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_axis_tdata <= result;
		end
	end

endmodule

`default_nettype wire
